>>> rtl/kspt_pkg.sv
// shared types and codes of the keyed shared page table
`default_nettype none
package kspt_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned MAX_PAGES_DEF     = 16;

  localparam logic [2:0] OP_ATTACH = 3'd0;
  localparam logic [2:0] OP_DETACH = 3'd1;
  localparam logic [2:0] OP_LOOKUP = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_QUERY  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_REJECT    = 2'd1;
  localparam logic [1:0] ST_NO_SPACE  = 2'd2;
  localparam logic [1:0] ST_UNDERFLOW = 2'd3;

  localparam logic [15:0] REFS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] object_key;
    logic [4:0]  page_count;
    logic [3:0]  page_slot;
    logic [27:0] offered_frame;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_index;
    logic [27:0] frame_out;
    logic        is_release;
    logic        frame_taken;
    logic        deleted_flag;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [31:0] key;
    logic [4:0]  pages;
    logic [15:0] refs;
    logic        deleted;
  } entry_t;

endpackage
`default_nettype wire

>>> rtl/keyed_shared_page_table.sv
// top level of the keyed shared page table
// a request runs a key scan over the entries, which stops at a match, then a decide
//   step; a page lookup adds a read of the frame memory; a release walks the page
//   slots of the object, reading and checking each one, and ends with a closing step
// throughput: one request at a time
// reset: a clearing pass over the frame memory runs after reset with s_axis_tready_o
//   low
`default_nettype none
module keyed_shared_page_table #(
  parameter int unsigned TABLE_ENTRIES = kspt_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned MAX_PAGES     = kspt_pkg::MAX_PAGES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // object_key, page_count, page_slot, offered_frame, zero fill
  input  wire logic [71:0] s_axis_tdata_i,
  // opcode
  input  wire logic [2:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // status, slot_index, frame_out, frame_taken, deleted_flag, zero fill
  output logic [39:0]      m_axis_tdata_o,
  // is_release
  output logic             m_axis_tuser_o,
  output logic             m_axis_tlast_o
);

  localparam int unsigned IDX_W    = $clog2(TABLE_ENTRIES);
  localparam int unsigned PG_W     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned FA_W     = IDX_W + PG_W;
  localparam int unsigned FR_DEPTH = TABLE_ENTRIES * (2 ** PG_W);
  localparam int unsigned ENT_W    = $bits(kspt_pkg::entry_t);

  kspt_pkg::req_t    req;
  kspt_pkg::result_t res;
  kspt_pkg::result_t out_q;
  logic              out_valid_q;
  logic              out_free;
  logic              emit;

  logic              ent_we, ent_re;
  logic [IDX_W-1:0]  ent_waddr, ent_raddr;
  kspt_pkg::entry_t  ent_wdata, ent_rdata;
  logic              fr_we, fr_re;
  logic [FA_W-1:0]   fr_waddr, fr_raddr;
  logic [27:0]       fr_wdata, fr_rdata;

  assign req.opcode        = s_axis_tuser_i;
  assign req.object_key    = s_axis_tdata_i[31:0];
  assign req.page_count    = s_axis_tdata_i[36:32];
  assign req.page_slot     = s_axis_tdata_i[40:37];
  assign req.offered_frame = s_axis_tdata_i[68:41];

  assign out_free = !out_valid_q || m_axis_tready_i;

  kspt_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .MAX_PAGES    (MAX_PAGES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_i       (req),
    .emit_o      (emit),
    .res_o       (res),
    .out_free_i  (out_free),
    .ent_we_o    (ent_we),
    .ent_waddr_o (ent_waddr),
    .ent_wdata_o (ent_wdata),
    .ent_re_o    (ent_re),
    .ent_raddr_o (ent_raddr),
    .ent_rdata_i (ent_rdata),
    .fr_we_o     (fr_we),
    .fr_waddr_o  (fr_waddr),
    .fr_wdata_o  (fr_wdata),
    .fr_re_o     (fr_re),
    .fr_raddr_o  (fr_raddr),
    .fr_rdata_i  (fr_rdata)
  );

  kspt_ram #(
    .DW   (ENT_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_entry_mem (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  kspt_ram #(
    .DW   (28),
    .DEPTH(FR_DEPTH)
  ) u_frame_mem (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .re_i    (fr_re),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_q.deleted_flag, out_q.frame_taken,
                            out_q.frame_out, out_q.slot_index, out_q.status};
  assign m_axis_tuser_o  = out_q.is_release;
  assign m_axis_tlast_o  = out_q.last;

endmodule
`default_nettype wire

>>> rtl/kspt_ram.sv
// simple dual-port synchronous ram with registered read
`default_nettype none
module kspt_ram #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DW-1:0]            wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> rtl/kspt_ctrl.sv
// request sequencer: key scan, entry update, page lookup and frame release walk
`default_nettype none
module kspt_ctrl #(
  parameter int unsigned TABLE_ENTRIES = kspt_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned MAX_PAGES     = kspt_pkg::MAX_PAGES_DEF,
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES),
  localparam int unsigned PG_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1,
  localparam int unsigned FA_W  = IDX_W + PG_W
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  input  wire kspt_pkg::req_t    req_i,
  output logic                   emit_o,
  output kspt_pkg::result_t      res_o,
  input  wire logic              out_free_i,
  output logic                   ent_we_o,
  output logic [IDX_W-1:0]       ent_waddr_o,
  output kspt_pkg::entry_t       ent_wdata_o,
  output logic                   ent_re_o,
  output logic [IDX_W-1:0]       ent_raddr_o,
  input  wire kspt_pkg::entry_t  ent_rdata_i,
  output logic                   fr_we_o,
  output logic [FA_W-1:0]        fr_waddr_o,
  output logic [27:0]            fr_wdata_o,
  output logic                   fr_re_o,
  output logic [FA_W-1:0]        fr_raddr_o,
  input  wire logic [27:0]       fr_rdata_i
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_DECIDE, S_LOOKUP, S_REL_RD, S_REL_CHK, S_REL_END
  } state_e;

  state_e              state_q, state_d;
  kspt_pkg::req_t      req_q, req_d;
  kspt_pkg::entry_t    ent_q, ent_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic                hit_q, hit_d;
  logic [IDX_W-1:0]    hit_idx_q, hit_idx_d;
  logic                free_q, free_d;
  logic [IDX_W-1:0]    free_idx_q, free_idx_d;
  logic [6:0]          j_q, j_d;
  logic [FA_W-1:0]     clr_q, clr_d;
  logic [TABLE_ENTRIES-1:0] used_q, used_d;
  logic                match;
  logic                oversize;
  logic                slot_bad;
  logic [FA_W-1:0]     rel_addr;
  logic [FA_W-1:0]     look_addr;

  assign req_ready_o = (state_q == S_IDLE);
  assign match     = used_q[idx_q] && (ent_rdata_i.key == req_q.object_key);
  assign oversize  = {2'b00, req_q.page_count} > 7'(MAX_PAGES);
  assign slot_bad  = ({1'b0, req_q.page_slot} >= ent_q.pages) ||
                     ({3'b000, req_q.page_slot} >= 7'(MAX_PAGES));
  assign rel_addr  = {hit_idx_q, PG_W'(j_q)};
  assign look_addr = {hit_idx_q, PG_W'(req_q.page_slot)};

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    ent_d      = ent_q;
    idx_d      = idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    j_d        = j_q;
    clr_d      = clr_q;
    used_d     = used_q;
    ent_we_o    = 1'b0;
    ent_waddr_o = hit_idx_q;
    ent_wdata_o = ent_q;
    ent_re_o    = 1'b0;
    ent_raddr_o = idx_q + 1'b1;
    fr_we_o     = 1'b0;
    fr_waddr_o  = rel_addr;
    fr_wdata_o  = '0;
    fr_re_o     = 1'b0;
    fr_raddr_o  = rel_addr;
    emit_o      = 1'b0;
    res_o       = '0;
    res_o.last  = 1'b1;
    res_o.status = kspt_pkg::ST_OK;

    case (state_q)
      S_CLEAR: begin
        fr_we_o    = 1'b1;
        fr_waddr_o = clr_q;
        clr_d      = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          req_d       = req_i;
          ent_re_o    = 1'b1;
          ent_raddr_o = '0;
          idx_d       = '0;
          hit_d       = 1'b0;
          free_d      = 1'b0;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!used_q[idx_q] && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = idx_q;
        end
        if (match) begin
          hit_d     = 1'b1;
          hit_idx_d = idx_q;
          ent_d     = ent_rdata_i;
          state_d   = S_DECIDE;
        end else if (idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_d = S_DECIDE;
        end else begin
          ent_re_o = 1'b1;
          idx_d    = idx_q + 1'b1;
        end
      end
      S_DECIDE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
          emit_o  = 1'b1;
          case (req_q.opcode)
            kspt_pkg::OP_ATTACH: begin
              if (oversize) begin
                res_o.status = kspt_pkg::ST_REJECT;
              end else if (hit_q) begin
                if (ent_q.deleted || (req_q.page_count > ent_q.pages) ||
                    (ent_q.refs == kspt_pkg::REFS_MAX)) begin
                  res_o.status = kspt_pkg::ST_REJECT;
                end else begin
                  ent_we_o         = 1'b1;
                  ent_wdata_o.refs = ent_q.refs + 1'b1;
                  res_o.slot_index = 4'(hit_idx_q);
                end
              end else if (free_q) begin
                ent_we_o            = 1'b1;
                ent_waddr_o         = free_idx_q;
                ent_wdata_o.key     = req_q.object_key;
                ent_wdata_o.pages   = req_q.page_count;
                ent_wdata_o.refs    = 16'd1;
                ent_wdata_o.deleted = 1'b0;
                used_d[free_idx_q]  = 1'b1;
                res_o.slot_index    = 4'(free_idx_q);
              end else begin
                res_o.status = kspt_pkg::ST_NO_SPACE;
              end
            end
            kspt_pkg::OP_DETACH: begin
              if (!hit_q) begin
                res_o.status = kspt_pkg::ST_REJECT;
              end else if (ent_q.refs == 16'd0) begin
                res_o.status = kspt_pkg::ST_UNDERFLOW;
              end else if (ent_q.refs == 16'd1) begin
                emit_o  = 1'b0;
                j_d     = '0;
                state_d = S_REL_RD;
              end else begin
                ent_we_o         = 1'b1;
                ent_wdata_o.refs = ent_q.refs - 1'b1;
              end
            end
            kspt_pkg::OP_LOOKUP: begin
              if (!hit_q || slot_bad) begin
                res_o.status = kspt_pkg::ST_REJECT;
              end else begin
                emit_o     = 1'b0;
                fr_re_o    = 1'b1;
                fr_raddr_o = look_addr;
                state_d    = S_LOOKUP;
              end
            end
            kspt_pkg::OP_REMOVE: begin
              if (!hit_q) begin
                res_o.status = kspt_pkg::ST_REJECT;
              end else if (ent_q.refs == 16'd0) begin
                emit_o  = 1'b0;
                j_d     = '0;
                state_d = S_REL_RD;
              end else begin
                ent_we_o            = 1'b1;
                ent_wdata_o.deleted = 1'b1;
              end
            end
            kspt_pkg::OP_QUERY: begin
              if (!hit_q) begin
                res_o.status = kspt_pkg::ST_REJECT;
              end else begin
                res_o.deleted_flag = ent_q.deleted;
              end
            end
            default: begin
              res_o.status = kspt_pkg::ST_REJECT;
            end
          endcase
        end
      end
      S_LOOKUP: begin
        if (out_free_i) begin
          emit_o  = 1'b1;
          state_d = S_IDLE;
          if (fr_rdata_i == '0) begin
            if (req_q.offered_frame == '0) begin
              res_o.status = kspt_pkg::ST_NO_SPACE;
            end else begin
              fr_we_o           = 1'b1;
              fr_waddr_o        = look_addr;
              fr_wdata_o        = req_q.offered_frame;
              res_o.frame_out   = req_q.offered_frame;
              res_o.frame_taken = 1'b1;
            end
          end else begin
            res_o.frame_out = fr_rdata_i;
          end
        end
      end
      S_REL_RD: begin
        if (j_q >= {2'b00, ent_q.pages}) begin
          state_d = S_REL_END;
        end else begin
          fr_re_o = 1'b1;
          state_d = S_REL_CHK;
        end
      end
      S_REL_CHK: begin
        if (fr_rdata_i == '0) begin
          j_d     = j_q + 1'b1;
          state_d = S_REL_RD;
        end else if (out_free_i) begin
          emit_o           = 1'b1;
          res_o.last       = 1'b0;
          res_o.is_release = 1'b1;
          res_o.frame_out  = fr_rdata_i;
          fr_we_o          = 1'b1;
          j_d              = j_q + 1'b1;
          state_d          = S_REL_RD;
        end
      end
      S_REL_END: begin
        if (out_free_i) begin
          emit_o            = 1'b1;
          used_d[hit_idx_q] = 1'b0;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      used_q  <= '0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
      idx_q   <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      used_q  <= used_d;
      hit_q   <= hit_d;
      free_q  <= free_d;
      idx_q   <= idx_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    ent_q      <= ent_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
  end

endmodule
`default_nettype wire

>>> rtl/kspt_checker.sv
// port-level checks of the keyed shared page table and their bind
`default_nettype none
module kspt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [39:0] m_axis_tdata_o,
  input wire logic        m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  a_release_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> !m_axis_tlast_o)
    else $error("release transfer marked last");

  a_release_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      (m_axis_tdata_o[33:6] != 28'd0) && (m_axis_tdata_o[1:0] == 2'd0))
    else $error("release transfer without frame or with error status");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while another is in progress");

  a_taken_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[34] |->
      (m_axis_tdata_o[1:0] == 2'd0) && m_axis_tlast_o)
    else $error("frame taken on a failed or non-final transfer");

endmodule

bind keyed_shared_page_table kspt_checker u_kspt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
`default_nettype wire
